// ----- hdl/itp_pkg.sv -----
// itp_pkg: shared types, codes, character classes and the sequencer control store
// for the infix to postfix converter; no dependencies
`timescale 1ns / 1ps

package itp_pkg;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       flush;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    status_t    status;
  } out_beat_t;

  // precedence code: 0 stands for -1 (anything not an operator)
  typedef logic [1:0] prec_t;

  // sequencer step addresses
  typedef enum logic [3:0] {
    U_IDLE    = 4'd0,
    U_DISP    = 4'd1,
    U_F_RD    = 4'd2,
    U_F_POP   = 4'd3,
    U_C_RD    = 4'd4,
    U_C_TEST  = 4'd5,
    U_C_POP   = 4'd6,
    U_C_DROP  = 4'd7,
    U_C_UNM   = 4'd8,
    U_O_RD    = 4'd9,
    U_O_TEST  = 4'd10,
    U_O_POP   = 4'd11,
    U_EMITC   = 4'd12,
    U_OVF     = 4'd13,
    U_PUSH    = 4'd14,
    U_FIN     = 4'd15
  } upc_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_BEAT,
    C_CNT_ZERO,
    C_TOP_LPAREN,
    C_PREC_GT,
    C_FULL,
    C_DISPATCH
  } cond_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CHAR,
    EM_TOP,
    EM_OVF,
    EM_UNM
  } emit_t;

  typedef struct packed {
    cond_t cond;
    upc_t  target;
    logic  rd;
    logic  wr;
    logic  inc;
    logic  dec;
    emit_t emit;
    logic  fin;
  } ucode_t;

  function automatic prec_t precedence(input logic [7:0] c);
    prec_t p;
    p = 2'd0;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic ucode_t uword(input cond_t cond, input upc_t target, input logic rd,
                                   input logic wr, input logic inc, input logic dec,
                                   input emit_t emit, input logic fin);
    ucode_t w;
    w.cond   = cond;
    w.target = target;
    w.rd     = rd;
    w.wr     = wr;
    w.inc    = inc;
    w.dec    = dec;
    w.emit   = emit;
    w.fin    = fin;
    return w;
  endfunction

  // control store: a conditional step jumps to target when its condition holds, else
  // acts and falls through (idle waits); always steps act and jump; dispatch by class
  function automatic ucode_t ucode_rom(input upc_t a);
    ucode_t w;
    unique case (a)
      U_IDLE:   w = uword(C_IN_BEAT,    U_DISP,   1'b0, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_DISP:   w = uword(C_DISPATCH,   U_IDLE,   1'b0, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_F_RD:   w = uword(C_CNT_ZERO,   U_FIN,    1'b1, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_F_POP:  w = uword(C_ALWAYS,     U_F_RD,   1'b0, 1'b0, 1'b0, 1'b1, EM_TOP,  1'b0);
      U_C_RD:   w = uword(C_CNT_ZERO,   U_C_UNM,  1'b1, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_C_TEST: w = uword(C_TOP_LPAREN, U_C_DROP, 1'b0, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_C_POP:  w = uword(C_ALWAYS,     U_C_RD,   1'b0, 1'b0, 1'b0, 1'b1, EM_TOP,  1'b0);
      U_C_DROP: w = uword(C_ALWAYS,     U_FIN,    1'b0, 1'b0, 1'b0, 1'b1, EM_NONE, 1'b0);
      U_C_UNM:  w = uword(C_ALWAYS,     U_FIN,    1'b0, 1'b0, 1'b0, 1'b0, EM_UNM,  1'b0);
      U_O_RD:   w = uword(C_CNT_ZERO,   U_PUSH,   1'b1, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_O_TEST: w = uword(C_PREC_GT,    U_PUSH,   1'b0, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b0);
      U_O_POP:  w = uword(C_ALWAYS,     U_O_RD,   1'b0, 1'b0, 1'b0, 1'b1, EM_TOP,  1'b0);
      U_EMITC:  w = uword(C_ALWAYS,     U_FIN,    1'b0, 1'b0, 1'b0, 1'b0, EM_CHAR, 1'b0);
      U_OVF:    w = uword(C_ALWAYS,     U_FIN,    1'b0, 1'b0, 1'b0, 1'b0, EM_OVF,  1'b0);
      U_PUSH:   w = uword(C_FULL,       U_OVF,    1'b0, 1'b1, 1'b1, 1'b0, EM_NONE, 1'b0);
      U_FIN:    w = uword(C_ALWAYS,     U_IDLE,   1'b0, 1'b0, 1'b0, 1'b0, EM_NONE, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/itp_ram.sv -----
// itp_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/infix_to_postfix_converter_top.sv -----
// infix_to_postfix_converter_top: shunting-yard converter run by a microcoded sequencer
// depends on itp_pkg and itp_ram (operator stack)
//
//   channel  direction  payload               beat when
//   in_      input      itp_pkg::in_beat_t    in_valid & !in_stall
//   out_     output     itp_pkg::out_beat_t   out_valid & !out_stall
//
// steps per item: operand emits; '(' pushes; flush pops and emits every stack entry;
// other operator reads, compares and pops entries until the top ranks lower, then
// pushes; ')' reads, tests, pops until '(' (dropped) or unmatched; full push: overflow
// each result is held back in a pending register so its last flag is known before it leaves
// reset is synchronous: clears stack count, sequencer, held and output valid flags; stack contents stay undefined
// out_stall only holds the sequencer when a new result needs the full output register
`timescale 1ns / 1ps

module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  itp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output itp_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  itp_pkg::upc_t      upc_r, upc_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [7:0]         char_r, char_nxt;
  logic               flush_r, flush_nxt;
  logic               pend_v_r, pend_v_nxt;
  itp_pkg::out_beat_t pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  itp_pkg::out_beat_t out_r, out_nxt;

  itp_pkg::ucode_t    uw;
  itp_pkg::upc_t      disp_target;
  logic               cond_true;
  logic               gate;
  logic               out_free;
  logic               do_emit;
  logic               do_fin;
  logic               hold;
  logic               ram_we;
  logic               ram_re;
  logic [7:0]         ram_rdata;
  itp_pkg::out_beat_t emit_beat;

  assign uw       = itp_pkg::ucode_rom(upc_r);
  assign out_free = !out_valid_r || !out_stall;

  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (char_r),
    .re    (ram_re),
    .raddr (AW'(cnt_r - 1'b1)),
    .rdata (ram_rdata)
  );

  // multiway branch on the flush flag and the character class
  always_comb begin
    priority if (flush_r) begin
      disp_target = itp_pkg::U_F_RD;
    end else if (itp_pkg::is_operand(char_r)) begin
      disp_target = itp_pkg::U_EMITC;
    end else if (char_r == itp_pkg::CH_LPAREN) begin
      disp_target = itp_pkg::U_PUSH;
    end else if (char_r == itp_pkg::CH_RPAREN) begin
      disp_target = itp_pkg::U_C_RD;
    end else begin
      disp_target = itp_pkg::U_O_RD;
    end
  end

  always_comb begin
    unique case (uw.cond)
      itp_pkg::C_ALWAYS:     cond_true = 1'b1;
      itp_pkg::C_IN_BEAT:    cond_true = in_valid;
      itp_pkg::C_CNT_ZERO:   cond_true = (cnt_r == '0);
      itp_pkg::C_TOP_LPAREN: cond_true = (ram_rdata == itp_pkg::CH_LPAREN);
      itp_pkg::C_PREC_GT:    cond_true = itp_pkg::precedence(char_r) >
                                         itp_pkg::precedence(ram_rdata);
      itp_pkg::C_FULL:       cond_true = (cnt_r == CW'(STACK_DEPTH));
      itp_pkg::C_DISPATCH:   cond_true = 1'b1;
      default:               cond_true = 1'b0;
    endcase
  end

  assign gate    = (uw.cond == itp_pkg::C_ALWAYS) || !cond_true;
  assign do_emit = gate && (uw.emit != itp_pkg::EM_NONE);
  assign do_fin  = uw.fin && pend_v_r;
  // a step that must push the held result out waits for the output register
  assign hold    = (do_emit || do_fin) && pend_v_r && !out_free;

  // next step
  always_comb begin
    upc_nxt = upc_r;
    if (!hold) begin
      if (uw.cond == itp_pkg::C_DISPATCH) begin
        upc_nxt = disp_target;
      end else if (cond_true) begin
        upc_nxt = uw.target;
      end else if (uw.cond != itp_pkg::C_IN_BEAT) begin
        upc_nxt = itp_pkg::upc_t'(upc_r + 4'd1);
      end
    end
  end

  always_comb begin
    emit_beat.last = 1'b0;
    unique case (uw.emit)
      itp_pkg::EM_CHAR: begin
        emit_beat.out_char = char_r;
        emit_beat.status   = itp_pkg::ST_OK;
      end
      itp_pkg::EM_TOP: begin
        emit_beat.out_char = ram_rdata;
        emit_beat.status   = itp_pkg::ST_OK;
      end
      itp_pkg::EM_OVF: begin
        emit_beat.out_char = itp_pkg::CH_NUL;
        emit_beat.status   = itp_pkg::ST_OVERFLOW;
      end
      itp_pkg::EM_UNM: begin
        emit_beat.out_char = itp_pkg::CH_NUL;
        emit_beat.status   = itp_pkg::ST_UNMATCHED;
      end
      default: begin
        emit_beat.out_char = itp_pkg::CH_NUL;
        emit_beat.status   = itp_pkg::ST_OK;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    in_stall      = (upc_r != itp_pkg::U_IDLE);
    ram_we        = !hold && gate && uw.wr;
    ram_re        = gate && uw.rd;
    char_nxt      = char_r;
    flush_nxt     = flush_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (!in_stall && in_valid) begin
      char_nxt  = in_data.in_char;
      flush_nxt = in_data.flush;
    end
    if (!hold && gate) begin
      if (uw.inc) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (uw.dec) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
    if (do_emit && !hold) begin
      if (pend_v_r) begin
        out_nxt       = pend_r;
        out_nxt.last  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt   = emit_beat;
      pend_v_nxt = 1'b1;
    end
    if (do_fin && !hold) begin
      out_nxt       = pend_r;
      out_nxt.last  = 1'b1;
      out_valid_nxt = 1'b1;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= itp_pkg::U_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    flush_r <= flush_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cnt_r < CW'(STACK_DEPTH))
    else $error("stack write while full");

  a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == itp_pkg::U_IDLE) |-> !pend_v_r)
    else $error("held result left behind at item end");

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (upc_r == itp_pkg::U_DISP))
    else $error("accepted beat not dispatched");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("output register overwritten while stalled");

endmodule
